@@ design/dcmp_pkg.sv @@
// shared types and constants for the dc motor position controller
package dcmp_pkg;

    localparam int POWER_WIDTH = 15;
    localparam int PERIOD_WIDTH = 16;
    localparam int SCALED_WIDTH = 21;
    localparam int RECIP_WIDTH = 20;
    localparam int PRODUCT_WIDTH = POWER_WIDTH + PERIOD_WIDTH;
    localparam int QUOT_WIDTH = SCALED_WIDTH + RECIP_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    typedef logic [POWER_WIDTH-1:0] power_t;

    // 100 percent in Q7.8
    localparam power_t FULL_POWER = power_t'(25600);
    // 25600 = 1024 * 25; divide by 25 as multiply by ceil(2^24 / 25) then shift
    localparam int POWER_SHIFT = 10;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_WIDTH-1:0] RECIP_25 = RECIP_WIDTH'(671089);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_STOP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_LEVEL   = 2'd1,
        MODE_RISING  = 2'd2,
        MODE_FALLING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_FWD  = 2'd1,
        MOT_BWD  = 2'd2
    } motion_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_OVERCURRENT  = 3'd1,
        EV_ZERO_MARK    = 3'd2,
        EV_POSITION_SET = 3'd3,
        EV_TIMEOUT      = 3'd4
    } event_code_t;

    typedef enum logic [1:0] {
        CMD_ACCEPTED    = 2'd0,
        CMD_BUSY        = 2'd1,
        CMD_OVERCURRENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_NONE        = 2'd0,
        RES_OVERCURRENT = 2'd1,
        RES_TIMEOUT     = 2'd2
    } result_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_START_POWER    = 3'd0,
        REG_RAMP_INCREMENT = 3'd1,
        REG_PWM_PERIOD     = 3'd2,
        REG_ZERO_LEVEL     = 3'd3,
        REG_OVER_LEVEL     = 3'd4
    } reg_index_t;

    typedef struct packed {
        power_t                  start_power;
        power_t                  ramp_increment;
        logic [PERIOD_WIDTH-1:0] pwm_period;
        logic                    zero_level;
        logic                    over_level;
    } cfg_t;

    typedef struct packed {
        motion_t     motion;
        event_code_t evt;
        status_t     status;
        result_t     result;
        logic        clear;
    } info_t;

endpackage

@@ design/dcmp_ctrl.sv @@
// motion state machine: takes ticks and commands and registers the step result
module dcmp_ctrl #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dcmp_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [POSITION_WIDTH-1:0] encoder_count,
    input  logic                      zero_mark_pin,
    input  logic                      overcurrent_pin,
    input  logic [POSITION_WIDTH-1:0] target_position,
    input  dcmp_pkg::power_t          request_power,
    input  logic [1:0]                move_mode,
    input  logic [31:0]               timeout_ticks,
    output logic                      s1_valid,
    input  logic                      s1_stall,
    output dcmp_pkg::info_t           s1_info,
    output dcmp_pkg::power_t          s1_power
);
    import dcmp_pkg::*;

    motion_t                          motion_reg, motion_next;
    logic [1:0]                       mode_reg, mode_next;
    logic signed [POSITION_WIDTH-1:0] goal_reg, goal_next;
    power_t                           drive_reg, drive_next;
    power_t                           goal_power_reg, goal_power_next;
    logic [31:0]                      ticks_reg, ticks_next;
    logic [31:0]                      limit_reg, limit_next;
    logic                             prev_zero_reg, prev_zero_next;
    result_t                          result_reg, result_next;

    logic                             s1_valid_reg;
    info_t                            s1_info_reg;
    power_t                           s1_power_reg;

    logic                             accept;
    logic                             zero_now;
    logic                             over_now;
    logic                             stop_mark;
    logic                             arrived;
    logic signed [POSITION_WIDTH-1:0] count;
    logic signed [POSITION_WIDTH-1:0] target;
    logic [31:0]                      ticks_inc;
    logic [POWER_WIDTH:0]             ramp_sum;
    power_t                           ramp_capped;
    power_t                           start_capped;
    event_code_t                      evt;
    status_t                          status;
    logic                             clear;

    assign in_stall = s1_valid_reg && s1_stall;
    assign accept   = in_valid && !in_stall;

    assign count    = encoder_count;
    assign target   = target_position;
    assign zero_now = (zero_mark_pin == cfg.zero_level);
    assign over_now = (overcurrent_pin == cfg.over_level);

    assign ticks_inc    = (ticks_reg != '1) ? ticks_reg + 32'd1 : ticks_reg;
    assign ramp_sum     = {1'b0, drive_reg} + {1'b0, cfg.ramp_increment};
    assign ramp_capped  = (ramp_sum > {1'b0, FULL_POWER}) ? FULL_POWER
                                                          : ramp_sum[POWER_WIDTH-1:0];
    assign start_capped = (cfg.start_power > FULL_POWER) ? FULL_POWER : cfg.start_power;

    // zero mark stop by mode, prev_zero_reg holds the mark of the previous sample
    always_comb
    begin
        stop_mark = 1'b0;
        if (zero_now)
        begin
            stop_mark = (mode_reg == MODE_LEVEL) ||
                        ((mode_reg == MODE_RISING) && !prev_zero_reg);
        end
        else
        begin
            stop_mark = (mode_reg == MODE_FALLING) && prev_zero_reg;
        end
    end

    assign arrived = ((motion_reg == MOT_FWD) && (count >= goal_reg)) ||
                     ((motion_reg == MOT_BWD) && (count <= goal_reg));

    always_comb
    begin
        motion_next     = motion_reg;
        mode_next       = mode_reg;
        goal_next       = goal_reg;
        drive_next      = drive_reg;
        goal_power_next = goal_power_reg;
        ticks_next      = ticks_reg;
        limit_next      = limit_reg;
        prev_zero_next  = prev_zero_reg;
        result_next     = result_reg;
        evt             = EV_NONE;
        status          = CMD_ACCEPTED;
        clear           = 1'b0;
        case (op)
            OP_TICK:
            begin
                prev_zero_next = zero_now;
                if (over_now)
                begin
                    if (motion_reg != MOT_STOP)
                    begin
                        motion_next = MOT_STOP;
                        result_next = RES_OVERCURRENT;
                        evt         = EV_OVERCURRENT;
                    end
                end
                else if (motion_reg != MOT_STOP)
                begin
                    if (stop_mark)
                    begin
                        motion_next = MOT_STOP;
                        evt         = EV_ZERO_MARK;
                    end
                    else if (arrived)
                    begin
                        motion_next = MOT_STOP;
                        evt         = EV_POSITION_SET;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= limit_reg)
                        begin
                            motion_next = MOT_STOP;
                            result_next = RES_TIMEOUT;
                            evt         = EV_TIMEOUT;
                        end
                        else if (drive_reg < goal_power_reg)
                        begin
                            drive_next = ramp_capped;
                        end
                    end
                end
            end
            OP_SET:
            begin
                if (motion_reg != MOT_STOP)
                begin
                    status = CMD_BUSY;
                end
                else
                begin
                    prev_zero_next = zero_now;
                    if (over_now)
                    begin
                        status = CMD_OVERCURRENT;
                    end
                    else
                    begin
                        result_next = RES_NONE;
                        if (count != target)
                        begin
                            ticks_next      = '0;
                            limit_next      = timeout_ticks;
                            drive_next      = start_capped;
                            goal_power_next = request_power;
                            mode_next       = move_mode;
                            goal_next       = target;
                            motion_next     = (count < target) ? MOT_FWD : MOT_BWD;
                        end
                    end
                end
            end
            OP_STOP:
            begin
                motion_next = MOT_STOP;
                result_next = RES_NONE;
            end
            default:
            begin
                // clear position is refused only while moving
                if (motion_reg != MOT_STOP)
                begin
                    status = CMD_BUSY;
                end
                else
                begin
                    clear = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg     <= MOT_STOP;
            mode_reg       <= MODE_PLAIN;
            goal_reg       <= '0;
            drive_reg      <= '0;
            goal_power_reg <= '0;
            ticks_reg      <= '0;
            limit_reg      <= '0;
            prev_zero_reg  <= 1'b0;
            result_reg     <= RES_NONE;
        end
        else if (accept)
        begin
            motion_reg     <= motion_next;
            mode_reg       <= mode_next;
            goal_reg       <= goal_next;
            drive_reg      <= drive_next;
            goal_power_reg <= goal_power_next;
            ticks_reg      <= ticks_next;
            limit_reg      <= limit_next;
            prev_zero_reg  <= prev_zero_next;
            result_reg     <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg.motion <= motion_next;
            s1_info_reg.evt    <= evt;
            s1_info_reg.status <= status;
            s1_info_reg.result <= result_next;
            s1_info_reg.clear  <= clear;
            s1_power_reg       <= (motion_next != MOT_STOP) ? drive_next : '0;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;
    assign s1_power = s1_power_reg;

endmodule

@@ design/dcmp_scale.sv @@
// two stage pwm compare scaling: power times period, then divide by full power
module dcmp_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      pwm_period,
    input  logic             s1_valid,
    output logic             s1_stall,
    input  dcmp_pkg::info_t  s1_info,
    input  dcmp_pkg::power_t s1_power,
    output logic             out_valid,
    input  logic             out_stall,
    output dcmp_pkg::info_t  out_info,
    output logic [15:0]      out_compare
);
    import dcmp_pkg::*;

    logic                      s2_valid_reg;
    info_t                     s2_info_reg;
    logic [SCALED_WIDTH-1:0]   s2_scaled_reg;
    logic                      out_valid_reg;
    info_t                     out_info_reg;
    logic [PERIOD_WIDTH-1:0]   out_compare_reg;

    logic                      out_free;
    logic                      s2_free;
    logic [PRODUCT_WIDTH-1:0]  product;
    logic [QUOT_WIDTH-1:0]     quot_full;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_stall = !s2_free;

    assign product   = PRODUCT_WIDTH'(s1_power) * PRODUCT_WIDTH'(pwm_period);
    // exact floor by 25 for every product that power and period can reach
    assign quot_full = QUOT_WIDTH'(s2_scaled_reg) * QUOT_WIDTH'(RECIP_25);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid)
        begin
            s2_info_reg   <= s1_info;
            s2_scaled_reg <= product[PRODUCT_WIDTH-1:POWER_SHIFT];
        end
        if (out_free && s2_valid_reg)
        begin
            out_info_reg    <= s2_info_reg;
            out_compare_reg <= quot_full[RECIP_SHIFT+PERIOD_WIDTH-1:RECIP_SHIFT];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_info    = out_info_reg;
    assign out_compare = out_compare_reg;

endmodule

@@ design/dc_motor_position_controller.sv @@
// top level of the dc motor position controller
//
//  channel | signals                               | accepted when
//  --------+---------------------------------------+--------------------------
//  in      | in_valid, in_stall, op .. timeout     | in_valid && !in_stall
//  out     | out_valid, out_stall, motion_state .. | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, data | cfg_valid && cfg_ready
//
// one request per cycle while in_stall is low; a result passes through registered stages after its
// request is accepted: state update, power-times-period multiply, reciprocal divide by 25
// reset clears all motion state and loads the register defaults at once
// in_stall rises only when every stage holds a result and out_stall is high
module dc_motor_position_controller #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [POSITION_WIDTH-1:0] encoder_count,
    input  logic                      zero_mark_pin,
    input  logic                      overcurrent_pin,
    input  logic [POSITION_WIDTH-1:0] target_position,
    input  logic [14:0]               request_power,
    input  logic [1:0]                move_mode,
    input  logic [31:0]               timeout_ticks,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                motion_state,
    output logic                      forward_enable,
    output logic                      backward_enable,
    output logic [15:0]               pwm_compare,
    output logic [2:0]                event_code,
    output logic [1:0]                command_status,
    output logic [1:0]                motion_result,
    output logic                      clear_encoder
);
    import dcmp_pkg::*;

    cfg_t   cfg_reg;
    logic   s1_valid;
    logic   s1_stall;
    info_t  s1_info;
    power_t s1_power;
    info_t  out_info;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_power    <= '0;
            cfg_reg.ramp_increment <= '0;
            cfg_reg.pwm_period     <= '1;
            cfg_reg.zero_level     <= 1'b1;
            cfg_reg.over_level     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_POWER:    cfg_reg.start_power    <= cfg_data[POWER_WIDTH-1:0];
                REG_RAMP_INCREMENT: cfg_reg.ramp_increment <= cfg_data[POWER_WIDTH-1:0];
                REG_PWM_PERIOD:     cfg_reg.pwm_period     <= cfg_data;
                REG_ZERO_LEVEL:     cfg_reg.zero_level     <= cfg_data[0];
                REG_OVER_LEVEL:     cfg_reg.over_level     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    dcmp_ctrl #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .encoder_count   (encoder_count),
        .zero_mark_pin   (zero_mark_pin),
        .overcurrent_pin (overcurrent_pin),
        .target_position (target_position),
        .request_power   (request_power),
        .move_mode       (move_mode),
        .timeout_ticks   (timeout_ticks),
        .s1_valid        (s1_valid),
        .s1_stall        (s1_stall),
        .s1_info         (s1_info),
        .s1_power        (s1_power)
    );

    dcmp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .pwm_period  (cfg_reg.pwm_period),
        .s1_valid    (s1_valid),
        .s1_stall    (s1_stall),
        .s1_info     (s1_info),
        .s1_power    (s1_power),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_info    (out_info),
        .out_compare (pwm_compare)
    );

    assign motion_state    = out_info.motion;
    assign forward_enable  = (out_info.motion == MOT_FWD);
    assign backward_enable = (out_info.motion == MOT_BWD);
    assign event_code      = out_info.evt;
    assign command_status  = out_info.status;
    assign motion_result   = out_info.result;
    assign clear_encoder   = out_info.clear;

    // a stopped motor never drives a compare value
    a_stopped_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (motion_state == MOT_STOP)) |-> (pwm_compare == 16'd0))
        else $error("compare value nonzero while stopped");

    // scaled compare stays within the period
    a_compare_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pwm_compare <= cfg_reg.pwm_period))
        else $error("compare value above pwm period");

    // encoder clear only from an accepted request with the motor stopped
    a_clear_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_encoder) |->
            ((motion_state == MOT_STOP) && (command_status == CMD_ACCEPTED) &&
             (event_code == EV_NONE)))
        else $error("encoder clear while moving");

    // a stop event always leaves the motor stopped
    a_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_code != EV_NONE)) |-> (motion_state == MOT_STOP))
        else $error("event reported while still moving");

    // a waiting result holds its motion state and other info fields across a stall
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_info)))
        else $error("stalled result changed");

endmodule

@@ bench/tb_dc_motor_position_controller.sv @@
// testbench for the dc motor position controller: scoreboard, stimulus and checks
module tb_dc_motor_position_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import dcmp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PLAN_COUNT = 6;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] count;
        logic               zero_pin;
        logic               over_pin;
        logic signed [31:0] target;
        power_t             power;
        mode_t              mode;
        logic [31:0]        timeout;
    } motor_req_t;

    typedef struct packed {
        motion_t     motion;
        logic        fwd;
        logic        bwd;
        logic [15:0] compare;
        event_code_t evt;
        status_t     status;
        result_t     result;
        logic        clear;
    } motor_res_t;

    class motor_scoreboard;
        cfg_t               regs;
        motion_t            motion;
        mode_t              mode;
        logic signed [31:0] goal_pos;
        power_t             drive_power;
        power_t             goal_power;
        logic [31:0]        move_ticks;
        logic [31:0]        move_limit;
        logic               prev_mark;
        result_t            last_result;
        motor_res_t         awaited[$];
        int                 errors;

        function new();
            regs.start_power = '0;
            regs.ramp_increment = '0;
            regs.pwm_period = 16'hFFFF;
            regs.zero_level = 1'b1;
            regs.over_level = 1'b1;
            motion = MOT_STOP;
            mode = MODE_PLAIN;
            goal_pos = '0;
            drive_power = '0;
            goal_power = '0;
            move_ticks = '0;
            move_limit = '0;
            prev_mark = 1'b0;
            last_result = RES_NONE;
            errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] data);
            case (idx)
                REG_START_POWER:    regs.start_power = data[14:0];
                REG_RAMP_INCREMENT: regs.ramp_increment = data[14:0];
                REG_PWM_PERIOD:     regs.pwm_period = data;
                REG_ZERO_LEVEL:     regs.zero_level = data[0];
                REG_OVER_LEVEL:     regs.over_level = data[0];
                default: ;
            endcase
        endfunction

        function power_t capped(logic [15:0] p);
            return (p > 16'(FULL_POWER)) ? FULL_POWER : p[14:0];
        endfunction

        function bit moving();
            return motion != MOT_STOP;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // advance the controller by one request and queue the result it produces
        function void note_request(motor_req_t r);
            motor_res_t res;
            logic       mark_now;
            logic       over_now;
            logic       mark_before;
            logic       hit_mark;
            res = '0;
            res.evt = EV_NONE;
            res.status = CMD_ACCEPTED;
            res.clear = 1'b0;
            mark_now = (r.zero_pin == regs.zero_level);
            over_now = (r.over_pin == regs.over_level);
            hit_mark = 1'b0;
            case (r.op)
                OP_TICK: begin
                    mark_before = prev_mark;
                    prev_mark = mark_now;
                    if (over_now) begin
                        if (motion != MOT_STOP) begin
                            motion = MOT_STOP;
                            last_result = RES_OVERCURRENT;
                            res.evt = EV_OVERCURRENT;
                        end
                    end else if (motion != MOT_STOP) begin
                        if (mark_now)
                            hit_mark = (mode == MODE_LEVEL) || (mode == MODE_RISING && !mark_before);
                        else
                            hit_mark = (mode == MODE_FALLING) && mark_before;
                        if (hit_mark) begin
                            motion = MOT_STOP;
                            res.evt = EV_ZERO_MARK;
                        end else if ((motion == MOT_FWD && $signed(r.count) >= goal_pos) ||
                                     (motion == MOT_BWD && $signed(r.count) <= goal_pos)) begin
                            motion = MOT_STOP;
                            res.evt = EV_POSITION_SET;
                        end else begin
                            if (move_ticks != 32'hFFFF_FFFF)
                                move_ticks++;
                            if (move_ticks >= move_limit) begin
                                motion = MOT_STOP;
                                last_result = RES_TIMEOUT;
                                res.evt = EV_TIMEOUT;
                            end else if (drive_power < goal_power) begin
                                drive_power = capped(16'(drive_power) + 16'(regs.ramp_increment));
                            end
                        end
                    end
                end
                OP_SET: begin
                    if (motion != MOT_STOP) begin
                        res.status = CMD_BUSY;
                    end else begin
                        prev_mark = mark_now;
                        if (over_now) begin
                            res.status = CMD_OVERCURRENT;
                        end else begin
                            last_result = RES_NONE;
                            if (r.count != r.target) begin
                                move_ticks = '0;
                                move_limit = r.timeout;
                                drive_power = capped(16'(regs.start_power));
                                goal_power = r.power;
                                mode = r.mode;
                                goal_pos = $signed(r.target);
                                motion = ($signed(r.count) < $signed(r.target)) ? MOT_FWD : MOT_BWD;
                            end
                        end
                    end
                end
                OP_STOP: begin
                    motion = MOT_STOP;
                    last_result = RES_NONE;
                end
                OP_CLEAR: begin
                    if (motion != MOT_STOP)
                        res.status = CMD_BUSY;
                    else
                        res.clear = 1'b1;
                end
                default: ;
            endcase
            res.motion = motion;
            res.fwd = (motion == MOT_FWD);
            res.bwd = (motion == MOT_BWD);
            if (motion != MOT_STOP)
                res.compare = 16'((32'(drive_power) * 32'(regs.pwm_period)) / 32'(FULL_POWER));
            else
                res.compare = '0;
            res.result = last_result;
            awaited.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(motor_res_t got);
            motor_res_t want;
            if (awaited.size() == 0) begin
                report("result with no request waiting");
                return;
            end
            want = awaited.pop_front();
            if (got.motion !== want.motion)
                report($sformatf("motion_state got %0d want %0d", got.motion, want.motion));
            if (got.fwd !== want.fwd)
                report($sformatf("forward_enable got %0d want %0d", got.fwd, want.fwd));
            if (got.bwd !== want.bwd)
                report($sformatf("backward_enable got %0d want %0d", got.bwd, want.bwd));
            if (got.compare !== want.compare)
                report($sformatf("pwm_compare got %0d want %0d", got.compare, want.compare));
            if (got.evt !== want.evt)
                report($sformatf("event_code got %0d want %0d", got.evt, want.evt));
            if (got.status !== want.status)
                report($sformatf("command_status got %0d want %0d", got.status, want.status));
            if (got.result !== want.result)
                report($sformatf("motion_result got %0d want %0d", got.result, want.result));
            if (got.clear !== want.clear)
                report($sformatf("clear_encoder got %0d want %0d", got.clear, want.clear));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [31:0] encoder_count = '0;
    logic        zero_mark_pin = 1'b0;
    logic        overcurrent_pin = 1'b0;
    logic [31:0] target_position = '0;
    logic [14:0] request_power = '0;
    logic [1:0]  move_mode = '0;
    logic [31:0] timeout_ticks = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  motion_state;
    logic        forward_enable;
    logic        backward_enable;
    logic [15:0] pwm_compare;
    logic [2:0]  event_code;
    logic [1:0]  command_status;
    logic [1:0]  motion_result;
    logic        clear_encoder;

    motor_scoreboard    sb;
    cfg_t               plan[PLAN_COUNT];
    int                 send_idle = 27;
    int                 recv_idle = 53;
    int                 items_sent = 0;
    int                 cycle_count = 0;
    logic signed [31:0] shaft_pos = '0;
    bit                 mark_on = 1'b0;

    dc_motor_position_controller dut (.*);

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk) begin : watch
        motor_res_t seen;
        if (rst_n && out_valid && !out_stall) begin
            seen.motion = motion_t'(motion_state);
            seen.fwd = forward_enable;
            seen.bwd = backward_enable;
            seen.compare = pwm_compare;
            seen.evt = event_code_t'(event_code);
            seen.status = status_t'(command_status);
            seen.result = result_t'(motion_result);
            seen.clear = clear_encoder;
            sb.check_result(seen);
        end
    end

    function automatic cfg_t settings_of(int sp, int ri, int pp, int zl, int ol);
        cfg_t c;
        c.start_power = power_t'(sp);
        c.ramp_increment = power_t'(ri);
        c.pwm_period = 16'(pp);
        c.zero_level = 1'(zl);
        c.over_level = 1'(ol);
        return c;
    endfunction

    function automatic motor_req_t req_of(op_t o, logic [31:0] cnt, logic zp, logic ocp,
                                          logic [31:0] tgt, power_t pw, mode_t md,
                                          logic [31:0] lim);
        motor_req_t r;
        r.op = o;
        r.count = cnt;
        r.zero_pin = zp;
        r.over_pin = ocp;
        r.target = tgt;
        r.power = pw;
        r.mode = md;
        r.timeout = lim;
        return r;
    endfunction

    function automatic motor_req_t noise_req();
        return req_of(op_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                      1'($urandom_range(1)), $urandom, power_t'($urandom_range(0, 25600)),
                      mode_t'($urandom_range(3)), $urandom);
    endfunction

    function automatic logic level_for(bit active, logic level);
        return active ? level : !level;
    endfunction

    task automatic send(motor_req_t r);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        op <= r.op;
        encoder_count <= r.count;
        zero_mark_pin <= r.zero_pin;
        overcurrent_pin <= r.over_pin;
        target_position <= r.target;
        request_power <= r.power;
        move_mode <= r.mode;
        timeout_ticks <= r.timeout;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(cfg_t c);
        reg_index_t  idx;
        logic [15:0] val;
        idx = idx.first();
        repeat (idx.num()) begin
            case (idx)
                REG_START_POWER:    val = 16'(c.start_power);
                REG_RAMP_INCREMENT: val = 16'(c.ramp_increment);
                REG_PWM_PERIOD:     val = c.pwm_period;
                REG_ZERO_LEVEL:     val = 16'(c.zero_level);
                default:            val = 16'(c.over_level);
            endcase
            cfg_index <= idx;
            cfg_data <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx, val);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic directed();
        send(req_of(OP_TICK, 0, 1'b1, 1'b1, 0, 0, MODE_PLAIN, 0));    // overcurrent while stopped
        send(req_of(OP_CLEAR, 0, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        settle();
        load_settings(plan[0]);
        send(req_of(OP_SET, 0, 1'b0, 1'b1, 100, 25600, MODE_PLAIN, 50));
        send(req_of(OP_SET, 5, 1'b0, 1'b0, 5, 25600, MODE_PLAIN, 50));   // already at target
        send(req_of(OP_SET, 32'h8000_0000, 1'b0, 1'b0, 32'h7FFF_FFFF, 25600, MODE_PLAIN,
                    32'hFFFF_FFFF));
        send(req_of(OP_SET, 0, 1'b0, 1'b0, 9, 100, MODE_LEVEL, 3));
        send(req_of(OP_CLEAR, 0, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 0, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_SET, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h8000_0000, 12800, MODE_LEVEL, 100));
        send(req_of(OP_TICK, 0, 1'b1, 1'b0, 0, 0, MODE_PLAIN, 0));
        // rising edge mode starting inside the mark
        send(req_of(OP_SET, 0, 1'b1, 1'b0, 1000, 12800, MODE_RISING, 100));
        send(req_of(OP_TICK, 10, 1'b1, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 20, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 30, 1'b1, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_SET, 30, 1'b0, 1'b0, 0, 12800, MODE_FALLING, 100));
        send(req_of(OP_TICK, 25, 1'b1, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 20, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_SET, 20, 1'b0, 1'b0, 500, 25600, MODE_PLAIN, 2));
        send(req_of(OP_TICK, 21, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 22, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_SET, 22, 1'b0, 1'b0, 0, 25600, MODE_PLAIN, 0));
        send(req_of(OP_TICK, 21, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_SET, 22, 1'b0, 1'b0, 900, 25600, MODE_PLAIN, 50));
        send(req_of(OP_TICK, 23, 1'b0, 1'b1, 0, 0, MODE_PLAIN, 0));
        send(req_of(OP_SET, 22, 1'b0, 1'b0, 900, 25600, MODE_PLAIN, 50));
        send(req_of(OP_STOP, 22, 1'b0, 1'b0, 0, 0, MODE_PLAIN, 0));
    endtask

    // one move: a set request, then mostly ticks that walk the shaft until the move ends or the guard runs out
    task automatic random_move();
        motor_req_t r;
        int         pick;
        int         guard;
        int         step;
        r = noise_req();
        if ($urandom_range(9) == 0)
            shaft_pos = $urandom;
        pick = $urandom_range(9);
        r.op = OP_SET;
        r.count = shaft_pos;
        if (pick == 0)
            r.target = $urandom;
        else if (pick == 1)
            r.target = shaft_pos;
        else if (pick < 6)
            r.target = shaft_pos + $urandom_range(1, 400);
        else
            r.target = shaft_pos - $urandom_range(1, 400);
        pick = $urandom_range(11);
        if (pick == 0)
            r.timeout = $urandom;
        else if (pick < 3)
            r.timeout = $urandom_range(0, 5);
        else
            r.timeout = $urandom_range(20, 200);
        if ($urandom_range(4) == 0)
            mark_on = !mark_on;
        r.zero_pin = level_for(mark_on, sb.regs.zero_level);
        r.over_pin = level_for($urandom_range(11) == 0, sb.regs.over_level);
        send(r);
        guard = 0;
        while (sb.moving() && guard < 80) begin
            guard++;
            r = noise_req();
            pick = $urandom_range(99);
            if (pick < 3) begin
                r.op = OP_SET;
            end else if (pick < 6) begin
                r.op = OP_CLEAR;
            end else if (pick < 8) begin
                r.op = OP_STOP;
            end else begin
                r.op = OP_TICK;
                step = $urandom_range(0, 40);
                if (sb.motion == MOT_FWD)
                    shaft_pos = shaft_pos + step;
                else
                    shaft_pos = shaft_pos - step;
                if ($urandom_range(5) == 0)
                    mark_on = !mark_on;
                r.over_pin = level_for($urandom_range(39) == 0, sb.regs.over_level);
            end
            r.count = shaft_pos;
            r.zero_pin = level_for(mark_on, sb.regs.zero_level);
            send(r);
        end
        repeat ($urandom_range(0, 2)) begin
            r = noise_req();
            r.op = ($urandom_range(1) == 0) ? OP_TICK : OP_CLEAR;
            r.count = shaft_pos;
            r.zero_pin = level_for(mark_on, sb.regs.zero_level);
            send(r);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int goal_items;
        sb = new();
        plan[0] = settings_of(1280, 256, 65535, 1, 1);
        plan[1] = settings_of(0, 25600, 1, 0, 0);
        // start power above full scale, zero period
        plan[2] = settings_of(32767, 0, 0, 1, 0);
        plan[3] = settings_of(5000, 1, 40000, 0, 1);
        plan[4] = settings_of(25600, 12800, 65535, 1, 1);
        plan[5] = settings_of($urandom_range(0, 25600), $urandom_range(0, 3000),
                              $urandom_range(1, 65535), $urandom_range(1), $urandom_range(1));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 27 : (ph == 1) ? 53 : 0;
            recv_idle = (ph == 0) ? 53 : (ph == 1) ? 27 : 0;
            for (int k = 0; k < 2; k++) begin
                settle();
                load_settings(plan[ph * 2 + k]);
                goal_items = items_sent + RANDOM_ITEMS / PLAN_COUNT;
                while (items_sent < goal_items) begin
                    if ($urandom_range(99) < 15)
                        repeat ($urandom_range(1, 4)) send(noise_req());
                    else
                        random_move();
                end
            end
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
